// ===== hdl/gspa_pkg.sv =====
// Shared types and constants for the gated scan point averager.
// No dependencies; every other file of the block uses it.
package gspa_pkg;

	localparam int POINT_COUNT = 64;
	localparam int IDX_W       = $clog2(POINT_COUNT);
	localparam int RANGE_W     = 16;
	localparam int ANGLE_W     = 16;
	localparam int SUM_W       = 24;
	localparam int CNT_W       = 8;
	localparam int DIVD_W      = SUM_W + 1;
	localparam int STEP_W      = $clog2(DIVD_W);
	localparam int CFG_IDX_W   = 1;

	localparam logic [CNT_W-1:0]   COUNT_MAX   = '1;
	localparam logic [RANGE_W-1:0] LOWER_RESET = '0;
	localparam logic [RANGE_W-1:0] UPPER_RESET = '1;

	localparam logic FUNC_ACCUMULATE = 1'b0;
	localparam logic FUNC_READ       = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER = 1'b0,
		REG_UPPER = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV_R,
		S_DIV_A,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic        [CNT_W-1:0] cnt;
		logic signed [SUM_W-1:0] asum;
		logic        [SUM_W-1:0] rsum;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} store_wr_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/gspa_if.sv =====
// Valid/ready channels for sample items in and average items out.
// Depends on gspa_pkg.
interface gspa_in_if;
	logic                                valid;
	logic                                ready;
	logic                                func;
	logic        [gspa_pkg::IDX_W-1:0]   point_index;
	logic        [gspa_pkg::RANGE_W-1:0] sample_range;
	logic signed [gspa_pkg::ANGLE_W-1:0] sample_angle;

	modport source(output valid, func, point_index, sample_range, sample_angle, input ready);
	modport sink(input valid, func, point_index, sample_range, sample_angle, output ready);
endinterface

interface gspa_out_if;
	logic                                valid;
	logic                                ready;
	logic        [gspa_pkg::RANGE_W-1:0] average_range;
	logic signed [gspa_pkg::ANGLE_W-1:0] average_angle;
	logic        [gspa_pkg::CNT_W-1:0]   accepted_count;
	logic                                has_samples;

	modport source(output valid, average_range, average_angle, accepted_count, has_samples,
		input ready);
	modport sink(input valid, average_range, average_angle, accepted_count, has_samples,
		output ready);
endinterface

// ===== hdl/gated_scan_point_averager_core.sv =====
// Gated scan point averager: range-gated sums per point, rounded means on read; a read clears the entry.
// Accumulate item: memory read, then write back. Read item: two passes of the shared
// one-bit-per-cycle divider (25 quotient bits each), range then angle, then the result is
// loaded into the output register; a zero count skips the divider.
// Result stays in an output register until taken; a new item is accepted meanwhile.
// arst_n resets control state and limits (0 and 65535) and clears all entry valid bits (sums read 0).
module gated_scan_point_averager_core (
	input  logic                           clk,
	input  logic                           arst_n,
	gspa_in_if.sink                        samples,
	gspa_out_if.source                     averages,
	input  logic                           cfg_write,
	input  logic [gspa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gspa_pkg::RANGE_W-1:0]   cfg_data
);

	gspa_pkg::state_t state_q, state_d;

	logic                                func_q;
	logic        [gspa_pkg::IDX_W-1:0]   idx_q;
	logic        [gspa_pkg::RANGE_W-1:0] rng_q;
	logic signed [gspa_pkg::ANGLE_W-1:0] ang_q;
	logic        [gspa_pkg::RANGE_W-1:0] lower_q;
	logic        [gspa_pkg::RANGE_W-1:0] upper_q;
	logic        [gspa_pkg::CNT_W-1:0]   cnt_q;
	logic signed [gspa_pkg::SUM_W-1:0]   asum_q;
	logic        [gspa_pkg::RANGE_W-1:0] avg_r_q;
	logic signed [gspa_pkg::ANGLE_W-1:0] avg_a_q;
	logic                                out_valid_q;
	logic        [gspa_pkg::RANGE_W-1:0] out_r_q;
	logic signed [gspa_pkg::ANGLE_W-1:0] out_a_q;
	logic        [gspa_pkg::CNT_W-1:0]   out_c_q;

	logic                      accept;
	logic                      load_out;
	logic                      gate_ok;
	gspa_pkg::entry_t          rd_data;
	gspa_pkg::store_wr_t       wr;
	gspa_pkg::div_req_t        div_req;
	gspa_pkg::div_rsp_t        div_rsp;
	logic [gspa_pkg::SUM_W-1:0] amag;
	logic [gspa_pkg::RANGE_W-1:0] q16;

	assign accept  = samples.valid && samples.ready;
	assign gate_ok = (rng_q >= lower_q) && (rng_q <= upper_q)
	                 && (rd_data.cnt != gspa_pkg::COUNT_MAX);
	assign amag    = asum_q[gspa_pkg::SUM_W-1] ? gspa_pkg::SUM_W'(-asum_q)
	                                          : gspa_pkg::SUM_W'(asum_q);
	assign q16     = div_rsp.quotient[gspa_pkg::RANGE_W-1:0];

	gspa_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (samples.point_index),
		.wr      (wr),
		.rd_data (rd_data)
	);

	gspa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gspa_pkg::S_IDLE;
			lower_q     <= gspa_pkg::LOWER_RESET;
			upper_q     <= gspa_pkg::UPPER_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (gspa_pkg::cfg_reg_t'(cfg_index))
					gspa_pkg::REG_LOWER: lower_q <= cfg_data;
					gspa_pkg::REG_UPPER: upper_q <= cfg_data;
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (averages.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= samples.func;
			idx_q  <= samples.point_index;
			rng_q  <= samples.sample_range;
			ang_q  <= samples.sample_angle;
		end
		if (state_q == gspa_pkg::S_EXEC) begin
			cnt_q   <= rd_data.cnt;
			asum_q  <= rd_data.asum;
			avg_r_q <= '0;
			avg_a_q <= '0;
		end
		if (state_q == gspa_pkg::S_DIV_R && div_rsp.done) begin
			avg_r_q <= q16;
		end
		if (state_q == gspa_pkg::S_DIV_A && div_rsp.done) begin
			avg_a_q <= asum_q[gspa_pkg::SUM_W-1] ? -$signed(q16) : $signed(q16);
		end
		if (load_out) begin
			out_r_q <= avg_r_q;
			out_a_q <= avg_a_q;
			out_c_q <= cnt_q;
		end
	end

	always_comb begin
		state_d          = state_q;
		samples.ready    = 1'b0;
		load_out         = 1'b0;
		wr               = '0;
		wr.addr          = idx_q;
		div_req          = '0;
		div_req.divisor  = rd_data.cnt;
		unique case (state_q)
			gspa_pkg::S_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					state_d = gspa_pkg::S_EXEC;
				end
			end
			gspa_pkg::S_EXEC: begin
				if (func_q == gspa_pkg::FUNC_ACCUMULATE) begin
					wr.en        = gate_ok;
					wr.data.cnt  = rd_data.cnt + 1'b1;
					wr.data.rsum = rd_data.rsum + gspa_pkg::SUM_W'(rng_q);
					wr.data.asum = rd_data.asum + gspa_pkg::SUM_W'(ang_q);
					state_d      = gspa_pkg::S_IDLE;
				end else begin
					wr.en = 1'b1;
					if (rd_data.cnt == '0) begin
						state_d = gspa_pkg::S_EMIT;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = gspa_pkg::DIVD_W'(rd_data.rsum)
						                   + gspa_pkg::DIVD_W'(rd_data.cnt >> 1);
						state_d          = gspa_pkg::S_DIV_R;
					end
				end
			end
			gspa_pkg::S_DIV_R: begin
				div_req.divisor = cnt_q;
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = gspa_pkg::DIVD_W'(amag)
					                   + gspa_pkg::DIVD_W'(cnt_q >> 1);
					state_d          = gspa_pkg::S_DIV_A;
				end
			end
			gspa_pkg::S_DIV_A: begin
				div_req.divisor = cnt_q;
				if (div_rsp.done) begin
					state_d = gspa_pkg::S_EMIT;
				end
			end
			gspa_pkg::S_EMIT: begin
				if (!out_valid_q || averages.ready) begin
					load_out = 1'b1;
					state_d  = gspa_pkg::S_IDLE;
				end
			end
			default: state_d = gspa_pkg::S_IDLE;
		endcase
	end

	assign averages.valid          = out_valid_q;
	assign averages.average_range  = out_r_q;
	assign averages.average_angle  = out_a_q;
	assign averages.accepted_count = out_c_q;
	assign averages.has_samples    = out_c_q != '0;

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !samples.ready)
		else $error("item accepted while previous item in progress");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !averages.ready) |=> ($stable(out_r_q) && $stable(out_c_q)))
		else $error("pending result overwritten");
	a_write_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && func_q == gspa_pkg::FUNC_ACCUMULATE) |=> (state_q == gspa_pkg::S_IDLE))
		else $error("accumulate did not return to idle");
`endif

endmodule

// ===== hdl/gspa_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by range and angle.
// Depends on gspa_pkg.
module gspa_div (
	input  logic               clk,
	input  logic               arst_n,
	input  gspa_pkg::div_req_t req,
	output gspa_pkg::div_rsp_t rsp
);

	logic [gspa_pkg::DIVD_W-1:0] num_q;
	logic [gspa_pkg::CNT_W-1:0]  rem_q;
	logic [gspa_pkg::CNT_W-1:0]  den_q;
	logic [gspa_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;
	logic [gspa_pkg::CNT_W:0]    trial;
	logic                        fits;

	assign trial = {rem_q, num_q[gspa_pkg::DIVD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= gspa_pkg::STEP_W'(gspa_pkg::DIVD_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[gspa_pkg::DIVD_W-2:0], fits};
			rem_q <= fits ? gspa_pkg::CNT_W'(trial - {1'b0, den_q})
			              : trial[gspa_pkg::CNT_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

// ===== hdl/gspa_store.sv =====
// Per-point sum and count memory with registered read.
// Entries read as zero until written; depends on gspa_pkg.
module gspa_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [gspa_pkg::IDX_W-1:0] rd_addr,
	input  gspa_pkg::store_wr_t        wr,
	output gspa_pkg::entry_t           rd_data
);

	gspa_pkg::entry_t                  mem [gspa_pkg::POINT_COUNT];
	logic [gspa_pkg::POINT_COUNT-1:0]  vld_q;
	gspa_pkg::entry_t                  rd_q;
	logic                              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
